/* design/kat_pkg.sv */
`timescale 1ns / 1ps

package kat_pkg;

  localparam int TOK_BITS = 16;
  localparam int KW_COUNT = 7;
  localparam int MAX_RECS = 3;

  localparam logic [TOK_BITS-1:0] LEN_MAX = '1;

  localparam logic [4:0] K_NUMBER  = 5'd0;
  localparam logic [4:0] K_STRING  = 5'd1;
  localparam logic [4:0] K_IDENT   = 5'd2;
  localparam logic [4:0] K_VAR     = 5'd3;
  localparam logic [4:0] K_NUM_T   = 5'd4;
  localparam logic [4:0] K_STR_T   = 5'd5;
  localparam logic [4:0] K_BOOL_T  = 5'd6;
  localparam logic [4:0] K_BOOL    = 5'd7;
  localparam logic [4:0] K_PRINT   = 5'd8;
  localparam logic [4:0] K_PLUS    = 5'd9;
  localparam logic [4:0] K_MINUS   = 5'd10;
  localparam logic [4:0] K_STAR    = 5'd11;
  localparam logic [4:0] K_SLASH   = 5'd12;
  localparam logic [4:0] K_LPAREN  = 5'd13;
  localparam logic [4:0] K_RPAREN  = 5'd14;
  localparam logic [4:0] K_ASSIGN  = 5'd15;
  localparam logic [4:0] K_UNTERM  = 5'd16;
  localparam logic [4:0] K_INVALID = 5'd17;
  localparam logic [4:0] K_END     = 5'd18;

  typedef enum logic [3:0] {
    MODE_IDLE   = 4'b0001,
    MODE_NUMBER = 4'b0010,
    MODE_STRING = 4'b0100,
    MODE_IDENT  = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       stream_end;
  } byte_word_t;

  typedef struct packed {
    logic [4:0]          token_kind;
    logic [TOK_BITS-1:0] token_start;
    logic [TOK_BITS-1:0] token_length;
    logic                run_last;
  } tok_word_t;

  typedef struct packed {
    logic [1:0]                   cnt;
    tok_word_t [MAX_RECS-1:0]     rec;
  } tok_bundle_t;

  localparam logic [0:KW_COUNT-1][0:7][7:0] KW_TEXT = '{
    '{"v", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"n", "u", "m", "b", "e", "r", 8'h00, 8'h00},
    '{"s", "t", "r", "i", "n", "g", 8'h00, 8'h00},
    '{"b", "o", "o", "l", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"t", "r", "u", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"f", "a", "l", "s", "e", 8'h00, 8'h00, 8'h00},
    '{"p", "r", "i", "n", "t", 8'h00, 8'h00, 8'h00}
  };

  localparam logic [0:KW_COUNT-1][2:0] KW_LEN = '{
    3'd3, 3'd6, 3'd6, 3'd4, 3'd4, 3'd5, 3'd5
  };

  localparam logic [0:KW_COUNT-1][4:0] KW_KIND = '{
    K_VAR, K_NUM_T, K_STR_T, K_BOOL_T, K_BOOL, K_BOOL, K_PRINT
  };

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == " ") || (c == 8'h09) || (c == 8'h0a);
  endfunction

  function automatic logic [4:0] op_kind(logic [7:0] c);
    logic [4:0] kind;
    case (c)
      "+":     kind = K_PLUS;
      "-":     kind = K_MINUS;
      "*":     kind = K_STAR;
      "/":     kind = K_SLASH;
      "(":     kind = K_LPAREN;
      ")":     kind = K_RPAREN;
      "=":     kind = K_ASSIGN;
      default: kind = K_INVALID;
    endcase
    return kind;
  endfunction

  function automatic logic [KW_COUNT-1:0] kw_extend(logic [KW_COUNT-1:0] km,
                                                    logic [TOK_BITS-1:0] len,
                                                    logic [7:0] c);
    logic [KW_COUNT-1:0] keep;
    keep = '0;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (km[k] && (len < TOK_BITS'(KW_LEN[k])) && (KW_TEXT[k][len[2:0]] == c)) begin
        keep[k] = 1'b1;
      end
    end
    return keep;
  endfunction

  function automatic logic [4:0] kw_kind_of(logic [KW_COUNT-1:0] km,
                                            logic [TOK_BITS-1:0] len);
    logic [4:0] kind;
    kind = K_IDENT;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (km[k] && (len == TOK_BITS'(KW_LEN[k]))) begin
        kind = KW_KIND[k];
      end
    end
    return kind;
  endfunction

endpackage

/* design/kat_scan.sv */
`timescale 1ns / 1ps

module kat_scan import kat_pkg::*; #(
  parameter int OFFSET_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  byte_word_t  word,
  output tok_bundle_t bundle
);

  mode_t                 mode, mode_next;
  logic [OFFSET_BITS-1:0] start, start_next;
  logic [TOK_BITS-1:0]   len, len_next;
  logic [KW_COUNT-1:0]   km, km_next;
  logic [OFFSET_BITS-1:0] pos, pos_next;
  logic                  err, err_next;

  logic [7:0]            c;
  logic [OFFSET_BITS-1:0] pos_inc;
  logic [TOK_BITS-1:0]   len_inc;
  logic                  do_idle;
  logic [1:0]            n;
  tok_word_t [MAX_RECS-1:0] r;

  assign c       = word.char_in;
  assign pos_inc = pos + 1'b1;
  assign len_inc = (len == LEN_MAX) ? len : len + 1'b1;

  always_comb begin
    mode_next  = mode;
    start_next = start;
    len_next   = len;
    km_next    = km;
    pos_next   = pos_inc;
    err_next   = err;
    do_idle    = 1'b0;
    n          = '0;
    r          = '0;

    if (!err) begin
      unique case (mode)
        MODE_STRING: begin
          if (c == "\"") begin
            r[n] = '{K_STRING, TOK_BITS'(start), len, 1'b0};
            n = n + 2'd1;
            mode_next = MODE_IDLE;
          end else begin
            len_next = len_inc;
          end
        end
        MODE_NUMBER: begin
          if (is_digit(c) || (c == ".")) begin
            len_next = len_inc;
          end else begin
            do_idle = 1'b1;
          end
        end
        MODE_IDENT: begin
          if (is_digit(c) || is_alpha(c)) begin
            km_next  = kw_extend(km, len, c);
            len_next = len_inc;
          end else begin
            do_idle = 1'b1;
          end
        end
        MODE_IDLE: begin
          do_idle = 1'b1;
        end
        default: begin
          do_idle = 1'b1;
        end
      endcase
    end

    if (do_idle) begin
      if (mode == MODE_NUMBER) begin
        r[n] = '{K_NUMBER, TOK_BITS'(start), len, 1'b0};
        n = n + 2'd1;
      end else if (mode == MODE_IDENT) begin
        r[n] = '{kw_kind_of(km, len), TOK_BITS'(start), len, 1'b0};
        n = n + 2'd1;
      end
      mode_next = MODE_IDLE;
      km_next   = '0;
      if (is_digit(c)) begin
        mode_next  = MODE_NUMBER;
        start_next = pos;
        len_next   = TOK_BITS'(1);
      end else if (c == "\"") begin
        mode_next  = MODE_STRING;
        start_next = pos_inc;
        len_next   = '0;
      end else if (is_alpha(c)) begin
        mode_next  = MODE_IDENT;
        start_next = pos;
        len_next   = TOK_BITS'(1);
        km_next    = kw_extend('1, '0, c);
      end else if (!is_space(c)) begin
        r[n] = '{op_kind(c), TOK_BITS'(pos), TOK_BITS'(1), 1'b0};
        n = n + 2'd1;
        if (op_kind(c) == K_INVALID) begin
          err_next = 1'b1;
        end
      end
    end

    if (word.stream_end) begin
      if (!err_next) begin
        if (mode_next == MODE_STRING) begin
          r[n] = '{K_UNTERM, TOK_BITS'(start_next), len_next, 1'b0};
          n = n + 2'd1;
        end else if (mode_next == MODE_NUMBER) begin
          r[n] = '{K_NUMBER, TOK_BITS'(start_next), len_next, 1'b0};
          n = n + 2'd1;
        end else if (mode_next == MODE_IDENT) begin
          r[n] = '{kw_kind_of(km_next, len_next), TOK_BITS'(start_next), len_next, 1'b0};
          n = n + 2'd1;
        end
      end
      r[n] = '{K_END, TOK_BITS'(pos_inc), '0, 1'b0};
      n = n + 2'd1;
      mode_next  = MODE_IDLE;
      start_next = '0;
      len_next   = '0;
      km_next    = '0;
      pos_next   = '0;
      err_next   = 1'b0;
    end
  end

  assign bundle.cnt = n;
  assign bundle.rec = r;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_IDLE;
      start <= '0;
      len   <= '0;
      km    <= '0;
      pos   <= '0;
      err   <= 1'b0;
    end else if (step) begin
      mode  <= mode_next;
      start <= start_next;
      len   <= len_next;
      km    <= km_next;
      pos   <= pos_next;
      err   <= err_next;
    end
  end

endmodule

/* design/kat_drain.sv */
`timescale 1ns / 1ps

module kat_drain import kat_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  tok_bundle_t bundle,
  output logic        free,
  output logic        tok_valid,
  input  logic        tok_stall,
  output tok_word_t   tok_word
);

  logic [1:0]               cnt;
  tok_word_t [MAX_RECS-1:0] rec;
  logic                     take;

  assign tok_valid = (cnt != 2'd0);
  assign take      = tok_valid && !tok_stall;
  assign free      = (cnt == 2'd0) || ((cnt == 2'd1) && !tok_stall);

  always_comb begin
    tok_word          = rec[0];
    tok_word.run_last = (cnt == 2'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= bundle.cnt;
    end else if (take) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rec <= bundle.rec;
    end else if (take) begin
      rec <= {tok_word_t'('0), rec[MAX_RECS-1:1]};
    end
  end

endmodule

/* design/keyword_aware_tokenizer.sv */
`timescale 1ns / 1ps
// channel  | valid      | stall      | word
// ---------+------------+------------+------------------------------
// source   | byte_valid | byte_stall | byte_word (char_in, stream_end)
// tokens   | tok_valid  | tok_stall  | tok_word (kind, start, length, run_last)
//
// One source byte per cycle while byte_stall is low: byte register, one
// scan pass, token register. A byte is scanned from the byte register into
// the token register, up to three tokens per byte, sent one word per cycle
// while tok_stall is low; a byte with k > 1 tokens holds the source side.
// rst (synchronous) clears scan state and offsets and empties both registers.

module keyword_aware_tokenizer import kat_pkg::*; #(
  parameter int OFFSET_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  byte_word_t byte_word,
  output logic       tok_valid,
  input  logic       tok_stall,
  output tok_word_t  tok_word
);

  logic        full;
  byte_word_t  held;
  logic        free;
  logic        advance;
  tok_bundle_t bundle;

  assign advance    = full && free;
  assign byte_stall = full && !free;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (byte_valid && !byte_stall) begin
      full <= 1'b1;
    end else if (advance) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      held <= byte_word;
    end
  end

  kat_scan #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_scan (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .word   (held),
    .bundle (bundle)
  );

  kat_drain u_drain (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .bundle    (bundle),
    .free      (free),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall),
    .tok_word  (tok_word)
  );

endmodule

/* design/kat_checker.sv */
`timescale 1ns / 1ps

module kat_checker import kat_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       byte_stall,
  input logic       tok_valid,
  input logic       tok_stall,
  input tok_word_t  tok_word
);

  a_tok_hold: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_stall |=> tok_valid && $stable(tok_word))
    else $error("token word changed while stalled");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    tok_valid |-> tok_word.token_kind <= K_END)
    else $error("token kind out of range");

  a_end_word: assert property (@(posedge clk) disable iff (rst)
    tok_valid && (tok_word.token_kind == K_END) |->
      tok_word.run_last && (tok_word.token_length == '0))
    else $error("end marker not last or has length");

  a_op_length: assert property (@(posedge clk) disable iff (rst)
    tok_valid && (tok_word.token_kind >= K_PLUS) && (tok_word.token_kind <= K_ASSIGN) |->
      tok_word.token_length == TOK_BITS'(1))
    else $error("operator token length is not one");

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> tok_valid)
    else $error("source stalled with token register empty");

endmodule

bind keyword_aware_tokenizer kat_checker u_kat_checker (
  .clk        (clk),
  .rst        (rst),
  .byte_stall (byte_stall),
  .tok_valid  (tok_valid),
  .tok_stall  (tok_stall),
  .tok_word   (tok_word)
);

/* sim/kat_token_checker.sv */
`timescale 1ns / 1ps

module kat_token_checker import kat_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  input  logic       byte_stall,
  input  byte_word_t byte_word,
  input  logic       tok_valid,
  input  logic       tok_stall,
  input  tok_word_t  tok_word,
  output int         fail_count,
  output int         outstanding
);

  mode_t       scan_state;
  logic [15:0] tok_begin;
  logic [15:0] tok_len;
  logic [15:0] next_pos;
  logic        err_hold;
  string       ident_text;
  tok_word_t   byte_tokens[$];
  tok_word_t   tokens_due[$];

  function automatic logic numeric(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic letter(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic [4:0] word_kind(string s);
    if (s == "var") return K_VAR;
    if (s == "number") return K_NUM_T;
    if (s == "string") return K_STR_T;
    if (s == "bool") return K_BOOL_T;
    if ((s == "true") || (s == "false")) return K_BOOL;
    if (s == "print") return K_PRINT;
    return K_IDENT;
  endfunction

  function void clear_scan();
    scan_state = MODE_IDLE;
    tok_begin  = '0;
    tok_len    = '0;
    next_pos   = '0;
    err_hold   = 1'b0;
    ident_text = "";
  endfunction

  function void add_token(logic [4:0] kind, logic [15:0] start, logic [15:0] len);
    tok_word_t t;
    t.token_kind   = kind;
    t.token_start  = start;
    t.token_length = len;
    t.run_last     = 1'b0;
    byte_tokens.push_back(t);
  endfunction

  function void lengthen();
    if (tok_len != LEN_MAX) tok_len = tok_len + 16'd1;
  endfunction

  function void close_open();
    if (scan_state == MODE_NUMBER) begin
      add_token(K_NUMBER, tok_begin, tok_len);
    end else if (scan_state == MODE_IDENT) begin
      add_token(word_kind(ident_text), tok_begin, tok_len);
    end
    scan_state = MODE_IDLE;
  endfunction

  function void fresh_byte(logic [7:0] c, logic [15:0] pos);
    logic [4:0] op;
    if (numeric(c)) begin
      scan_state = MODE_NUMBER;
      tok_begin  = pos;
      tok_len    = 16'd1;
    end else if (c == "\"") begin
      scan_state = MODE_STRING;
      tok_begin  = pos + 16'd1;
      tok_len    = '0;
    end else if (letter(c)) begin
      scan_state = MODE_IDENT;
      tok_begin  = pos;
      tok_len    = 16'd1;
      ident_text = $sformatf("%c", c);
    end else if (!((c == " ") || (c == 8'h09) || (c == 8'h0a))) begin
      case (c)
        "+":     op = K_PLUS;
        "-":     op = K_MINUS;
        "*":     op = K_STAR;
        "/":     op = K_SLASH;
        "(":     op = K_LPAREN;
        ")":     op = K_RPAREN;
        "=":     op = K_ASSIGN;
        default: op = K_INVALID;
      endcase
      add_token(op, pos, 16'd1);
      if (op == K_INVALID) err_hold = 1'b1;
    end
  endfunction

  function void scan_byte(byte_word_t w);
    logic [7:0]  c;
    logic [15:0] pos;
    int          last_idx;
    c = w.char_in;
    pos = next_pos;
    byte_tokens.delete();
    if (!err_hold) begin
      if (scan_state == MODE_STRING) begin
        if (c == "\"") begin
          add_token(K_STRING, tok_begin, tok_len);
          scan_state = MODE_IDLE;
        end else begin
          lengthen();
        end
      end else if ((scan_state == MODE_NUMBER) && (numeric(c) || (c == "."))) begin
        lengthen();
      end else if ((scan_state == MODE_IDENT) && (numeric(c) || letter(c))) begin
        lengthen();
        if (ident_text.len() < 7) ident_text = $sformatf("%s%c", ident_text, c);
      end else begin
        close_open();
        fresh_byte(c, pos);
      end
    end
    if (w.stream_end) begin
      if (!err_hold) begin
        if (scan_state == MODE_STRING) add_token(K_UNTERM, tok_begin, tok_len);
        else close_open();
      end
      add_token(K_END, pos + 16'd1, '0);
      clear_scan();
    end else begin
      next_pos = pos + 16'd1;
    end
    last_idx = byte_tokens.size() - 1;
    if (last_idx >= 0) byte_tokens[last_idx].run_last = 1'b1;
    foreach (byte_tokens[i]) tokens_due.push_back(byte_tokens[i]);
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      fail_count++;
      $error("%s: expected %0d, actual %0d", name, want, got);
    end
  endtask

  task automatic take_token(tok_word_t got);
    tok_word_t want;
    if (tokens_due.size() == 0) begin
      fail_count++;
      $error("token word with none expected: kind %0d start %0d length %0d",
             got.token_kind, got.token_start, got.token_length);
      return;
    end
    want = tokens_due.pop_front();
    check_field("token_kind", 16'(want.token_kind), 16'(got.token_kind));
    check_field("token_start", want.token_start, got.token_start);
    check_field("token_length", want.token_length, got.token_length);
    check_field("run_last", 16'(want.run_last), 16'(got.run_last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_scan();
      tokens_due.delete();
    end else begin
      if (byte_valid && !byte_stall) scan_byte(byte_word);
      if (tok_valid && !tok_stall) take_token(tok_word);
    end
    outstanding = tokens_due.size();
  end

endmodule

/* sim/keyword_aware_tokenizer_tb.sv */
`timescale 1ns / 1ps

module keyword_aware_tokenizer_tb;
  import kat_pkg::*;

  localparam int CYCLE_LIMIT = 500000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       byte_valid = 1'b0;
  logic       byte_stall;
  byte_word_t byte_word = '0;
  logic       tok_valid;
  logic       tok_stall = 1'b0;
  tok_word_t  tok_word;

  int mismatches;
  int tokens_due;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycle_count = 0;
  int bytes_sent = 0;

  string kw_words[7] = '{"var", "number", "string", "bool", "true", "false", "print"};
  string op_chars = "+-*/()=";
  string ws_chars = " \t\n";

  keyword_aware_tokenizer uut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_word  (byte_word),
    .tok_valid  (tok_valid),
    .tok_stall  (tok_stall),
    .tok_word   (tok_word)
  );

  kat_token_checker chk (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .byte_word   (byte_word),
    .tok_valid   (tok_valid),
    .tok_stall   (tok_stall),
    .tok_word    (tok_word),
    .fail_count  (mismatches),
    .outstanding (tokens_due)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    tok_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] c, logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      @(negedge clk);
    end
    byte_valid <= 1'b1;
    byte_word <= '{char_in: c, stream_end: last};
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  // hold the source side until every expected word has come back
  task automatic hold_until_drained();
    @(negedge clk);
    byte_valid <= 1'b0;
    while (tokens_due != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] rand_letter();
    return $urandom_range(1) ? 8'("a" + $urandom_range(25)) : 8'("A" + $urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_alnum();
    return ($urandom_range(2) == 0) ? 8'("0" + $urandom_range(9)) : rand_letter();
  endfunction

  task automatic random_stream();
    logic [7:0] text[$];
    logic [7:0] b;
    int         target;
    int         pick;
    int         n;
    string      w;
    target = $urandom_range(1, 30);
    while (text.size() < target) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        text.push_back(8'("0" + $urandom_range(9)));
        repeat ($urandom_range(5)) begin
          text.push_back(($urandom_range(3) == 0) ? 8'(".") : 8'("0" + $urandom_range(9)));
        end
      end else if (pick < 45) begin
        w = kw_words[$urandom_range(6)];
        n = $urandom_range(5);
        if (n == 2) begin
          w = $sformatf("%c", rand_letter());
          repeat ($urandom_range(7)) w = $sformatf("%s%c", w, rand_alnum());
        end else if (n == 3) begin
          w = w.substr(0, w.len() - 2);
        end else if (n == 4) begin
          w = $sformatf("%s%c", w, rand_alnum());
        end else if (n == 5) begin
          w = w.toupper();
        end
        for (int i = 0; i < w.len(); i++) text.push_back(w[i]);
      end else if (pick < 60) begin
        text.push_back("\"");
        repeat ($urandom_range(6)) begin
          b = 8'($urandom_range(255));
          text.push_back((b == "\"") ? 8'("'") : b);
        end
        if ($urandom_range(9) != 0) text.push_back("\"");
      end else if (pick < 80) begin
        text.push_back(op_chars[$urandom_range(6)]);
      end else if (pick < 92) begin
        text.push_back(ws_chars[$urandom_range(2)]);
      end else begin
        text.push_back(8'($urandom_range(255)));
      end
      if ($urandom_range(1) == 0) text.push_back(" ");
    end
    for (int i = 0; i < text.size(); i++) send_byte(text[i], i == text.size() - 1);
  endtask

  task automatic send_random(int count);
    int first;
    first = bytes_sent;
    while (bytes_sent - first < count) random_stream();
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 18;
    recv_stall_pct = 70;
    send_text("1.5+a");
    send_text("true-\"q");
    send_text("(*/)=\t\n");
    send_text("a+");
    send_text("\"");
    send_byte(8'h00, 1'b0);
    send_byte("z", 1'b0);
    send_byte(8'hff, 1'b1);
    send_random(90);
    hold_until_drained();

    send_idle_pct = 70;
    recv_stall_pct = 18;
    send_random(95);
    hold_until_drained();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_random(95);
    hold_until_drained();

    repeat (8) @(negedge clk);
    if ((mismatches == 0) && (tokens_due == 0)) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
